// ===== hdl/lps_pkg.sv =====
// Shared constants and types of the line position steering block.
`default_nettype none
package lps_pkg;

  localparam int BINS         = 128;
  localparam int FRAME_WIDTH  = 1280;
  localparam int FRAME_HEIGHT = 720;
  localparam int BAND_ROWS    = 10;

  localparam int BIN_W   = FRAME_WIDTH / BINS;
  localparam int BIN_DIV = BIN_W * BAND_ROWS;

  localparam int PIX_W     = 8;
  localparam int COL_W     = 11;
  localparam int ROW_W     = 10;
  localparam int THR_W     = 8;
  localparam int SPEED_W   = 7;
  localparam int OUT_SPD_W = 9;
  localparam int POS_W     = 7;

  localparam int BIN_IDX_W = $clog2(BINS);
  localparam int SUM_W     = 15;
  localparam int MEAN_W    = 9;

  localparam int MUL_B_W    = 13;
  localparam int PROD_W     = SUM_W + MUL_B_W;
  localparam int BIN_SHIFT  = 15;
  localparam int BIN_RECIP  = (2 ** BIN_SHIFT + BIN_W - 1) / BIN_W;
  localparam int MEAN_SHIFT = 19;
  localparam int MEAN_RECIP = (2 ** MEAN_SHIFT + BIN_DIV - 1) / BIN_DIV;

  localparam int DIV_W     = $clog2(BINS + 1);
  localparam int DIV_CNT_W = $clog2(DIV_W);

  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_ADDR_W-1:0] CFG_BAND_TOP   = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_DARK_THR   = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE_SPEED = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_SRCH_SPEED = 4'd3;

  typedef logic signed [OUT_SPD_W-1:0] wheel_speed_t;

endpackage
`default_nettype wire

// ===== hdl/lps_pixel_if.sv =====
// Pixel stream channel carrying one luma word with its coordinates.
`default_nettype none
interface lps_pixel_if;
  import lps_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] row;
  logic             frame_end;
  modport source(output valid, output pixel, output column, output row, output frame_end,
                 input ready);
  modport sink(input valid, input pixel, input column, input row, input frame_end,
               output ready);
endinterface
`default_nettype wire

// ===== hdl/lps_result_if.sv =====
// Result channel carrying the wheel speed word of one frame.
`default_nettype none
interface lps_result_if;
  import lps_pkg::*;
  logic             valid;
  logic             ready;
  wheel_speed_t     left_speed;
  wheel_speed_t     right_speed;
  logic             line_found;
  logic [POS_W-1:0] line_position;
  modport source(output valid, output left_speed, output right_speed, output line_found,
                 output line_position, input ready);
  modport sink(input valid, input left_speed, input right_speed, input line_found,
               input line_position, output ready);
endinterface
`default_nettype wire

// ===== hdl/lps_cfg_if.sv =====
// Configuration write channel carrying a register index and its data word.
`default_nettype none
interface lps_cfg_if;
  import lps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_ADDR_W-1:0] addr;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output addr, output data, input ready);
  modport sink(input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ===== hdl/line_position_steering.sv =====
// Line position steering: column bin accumulation, dark bin search and wheel speeds.
// The pixel channel takes raster pixels; pixels in the ten-row band starting at
// band_top_row are added into 128 column bins held in a RAM.
// A pixel inside the band passes latch, bin index, read and write back;
// one outside passes only latch and bin index. The RAM read-modify-write sets this.
// The pixel marked frame_end is accumulated first, then the block scans the bins,
// each by read, multiply on the shared multiplier and compare, divides with a
// bit-serial divider, left then right, when a line is found, and loads the result.
// The next pixel is taken only after the result is loaded.
// One result word per frame leaves on the result channel from an output register;
// pixels of the next frame are taken while it waits. If a new frame end arrives
// while the previous result is still waiting, the block holds until it is taken.
// Reset clears the bin valid flags at once (no clearing pass), forgets the last
// line position and loads the register defaults. Configuration writes are taken
// at any time and apply to the following pixels.
`default_nettype none
module line_position_steering (
  input wire logic      clk,
  input wire logic      rst,
  lps_pixel_if.sink     pix,
  lps_result_if.source  res,
  lps_cfg_if.sink       cfg
);
  import lps_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_BIN      = 4'd1;
  localparam logic [3:0] S_RD       = 4'd2;
  localparam logic [3:0] S_WR       = 4'd3;
  localparam logic [3:0] S_SCAN_RD  = 4'd4;
  localparam logic [3:0] S_SCAN_MUL = 4'd5;
  localparam logic [3:0] S_SCAN_CMP = 4'd6;
  localparam logic [3:0] S_DIV_L    = 4'd7;
  localparam logic [3:0] S_DIV_R    = 4'd8;
  localparam logic [3:0] S_FIN      = 4'd9;

  localparam int ROW_END_W = ROW_W + 1;
  localparam int HALF      = BINS / 2;

  logic [3:0]           state;
  logic [ROW_W-1:0]     band_top_row;
  logic [THR_W-1:0]     dark_threshold;
  logic [SPEED_W-1:0]   base_speed;
  logic [SPEED_W-1:0]   search_speed;

  logic [PIX_W-1:0]     in_pix;
  logic [COL_W-1:0]     in_col;
  logic [ROW_W-1:0]     in_row;
  logic                 in_fend;

  logic [BIN_IDX_W-1:0] bin;
  logic [BIN_IDX_W-1:0] idx;
  logic [BINS-1:0]      bin_vld;
  logic                 cur_vld;
  logic [MEAN_W-1:0]    mean;
  logic [THR_W-1:0]     best;
  logic                 found;
  logic [BIN_IDX_W-1:0] pos;
  logic [BIN_IDX_W-1:0] last_pos;
  logic                 last_vld;

  logic [DIV_W-1:0]     div_d;
  logic [DIV_W-1:0]     div_rem;
  logic [DIV_W-1:0]     div_q;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [DIV_W-1:0]     q_left;
  logic [DIV_W-1:0]     q_right;

  logic                 out_valid;
  wheel_speed_t         out_left;
  wheel_speed_t         out_right;
  logic                 out_found;
  logic [POS_W-1:0]     out_pos;

  logic                 ram_we;
  logic [BIN_IDX_W-1:0] ram_raddr;
  logic [SUM_W-1:0]     ram_rdata;
  logic [SUM_W-1:0]     ram_wdata;

  logic [SUM_W-1:0]     cur_sum;
  logic [SUM_W-1:0]     mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [ROW_END_W-1:0] band_end;
  logic                 hit;
  logic [SUM_W:0]       sum_add;
  logic                 start_scan;
  logic                 cmp_hit;
  logic [BIN_IDX_W-1:0] pos_fin;
  logic                 found_fin;
  logic [DIV_W-1:0]     pos_ext;
  logic [DIV_W-1:0]     center_off;
  logic [DIV_W:0]       trial;
  logic                 trial_ge;
  logic [DIV_W-1:0]     rem_next;
  logic [DIV_W-1:0]     q_next;
  logic                 div_last;
  logic                 fin_load;
  logic                 spin_left;
  logic [OUT_SPD_W-1:0] spin_mag;
  logic [OUT_SPD_W-1:0] left_sum;
  logic [OUT_SPD_W-1:0] right_sum;

  function automatic logic [OUT_SPD_W-1:0] sat_speed(input logic [OUT_SPD_W-1:0] v);
    logic [OUT_SPD_W-1:0] lim;
    lim = OUT_SPD_W'(255);
    return (v > lim) ? lim : v;
  endfunction

  lps_ram #(.WIDTH(SUM_W), .DEPTH(BINS)) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (bin),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign pix.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign res.valid         = out_valid;
  assign res.left_speed    = out_left;
  assign res.right_speed   = out_right;
  assign res.line_found    = out_found;
  assign res.line_position = out_pos;

  assign cur_sum = cur_vld ? ram_rdata : '0;

  always_comb begin
    if (state == S_BIN) begin
      mul_a = SUM_W'(in_col);
      mul_b = MUL_B_W'(BIN_RECIP);
    end else begin
      mul_a = cur_sum;
      mul_b = MUL_B_W'(MEAN_RECIP);
    end
  end
  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  assign band_end = ROW_END_W'(band_top_row) + ROW_END_W'(BAND_ROWS);
  assign hit = (in_row >= band_top_row) && (ROW_END_W'(in_row) < band_end) &&
               (in_row < ROW_W'(FRAME_HEIGHT)) && (in_col < COL_W'(FRAME_WIDTH));

  assign sum_add   = (SUM_W + 1)'(cur_sum) + (SUM_W + 1)'(in_pix);
  assign ram_wdata = sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
  assign ram_we    = (state == S_WR);
  assign ram_raddr = (state == S_RD) ? bin : idx;

  assign start_scan = in_fend && (((state == S_BIN) && !hit) || (state == S_WR));

  assign cmp_hit    = mean < MEAN_W'(best);
  assign pos_fin    = cmp_hit ? idx : pos;
  assign found_fin  = found || cmp_hit;
  assign pos_ext    = DIV_W'(pos_fin);
  assign center_off = (pos_ext >= DIV_W'(HALF)) ? pos_ext - DIV_W'(HALF)
                                                 : DIV_W'(HALF) - pos_ext;

  assign trial    = {div_rem, div_q[DIV_W-1]};
  assign trial_ge = trial >= (DIV_W + 1)'(div_d);
  assign rem_next = trial_ge ? DIV_W'(trial - (DIV_W + 1)'(div_d)) : DIV_W'(trial);
  assign q_next   = {div_q[DIV_W-2:0], trial_ge};
  assign div_last = (div_cnt == DIV_CNT_W'(DIV_W - 1));

  assign fin_load  = (state == S_FIN) && (!out_valid || res.ready);
  assign spin_left = !last_vld || (last_pos < BIN_IDX_W'(HALF));
  assign spin_mag  = OUT_SPD_W'(search_speed);
  assign left_sum  = sat_speed(OUT_SPD_W'(base_speed) + OUT_SPD_W'(q_left));
  assign right_sum = sat_speed(OUT_SPD_W'(base_speed) + OUT_SPD_W'(q_right));

  always_ff @(posedge clk) begin
    cur_vld <= bin_vld[ram_raddr];
    if (pix.valid && pix.ready) begin
      in_pix  <= pix.pixel;
      in_col  <= pix.column;
      in_row  <= pix.row;
      in_fend <= pix.frame_end;
    end
    if (state == S_BIN) begin
      bin <= prod[BIN_SHIFT +: BIN_IDX_W];
    end
    if (state == S_SCAN_MUL) begin
      mean <= prod[MEAN_SHIFT +: MEAN_W];
    end
    if (start_scan) begin
      idx   <= '0;
      best  <= dark_threshold;
      found <= 1'b0;
      pos   <= '0;
    end
    if (state == S_SCAN_CMP) begin
      if (cmp_hit) begin
        best  <= THR_W'(mean);
        pos   <= idx;
        found <= 1'b1;
      end
      idx     <= idx + 1'b1;
      div_d   <= (center_off >> 3) + 1'b1;
      div_q   <= pos_ext;
      div_rem <= '0;
      div_cnt <= '0;
    end
    if ((state == S_DIV_L) || (state == S_DIV_R)) begin
      if (div_last && (state == S_DIV_L)) begin
        q_left  <= q_next;
        div_rem <= '0;
        div_cnt <= '0;
        div_q   <= DIV_W'(BINS) - DIV_W'(pos);
      end else begin
        div_rem <= rem_next;
        div_q   <= q_next;
        div_cnt <= div_cnt + 1'b1;
      end
      if (div_last && (state == S_DIV_R)) begin
        q_right <= q_next;
      end
    end
    if (fin_load) begin
      out_found <= found;
      out_pos   <= POS_W'(pos);
      if (found) begin
        out_left  <= wheel_speed_t'(left_sum);
        out_right <= wheel_speed_t'(right_sum);
      end else if (spin_left) begin
        out_left  <= wheel_speed_t'(OUT_SPD_W'(0) - spin_mag);
        out_right <= wheel_speed_t'(spin_mag);
      end else begin
        out_left  <= wheel_speed_t'(spin_mag);
        out_right <= wheel_speed_t'(OUT_SPD_W'(0) - spin_mag);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      band_top_row   <= ROW_W'(635);
      dark_threshold <= THR_W'(50);
      base_speed     <= SPEED_W'(32);
      search_speed   <= SPEED_W'(64);
      bin_vld        <= '0;
      last_vld       <= 1'b0;
      last_pos       <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.addr)
          CFG_BAND_TOP:   band_top_row   <= cfg.data[ROW_W-1:0];
          CFG_DARK_THR:   dark_threshold <= cfg.data[THR_W-1:0];
          CFG_BASE_SPEED: base_speed     <= cfg.data[SPEED_W-1:0];
          CFG_SRCH_SPEED: search_speed   <= cfg.data[SPEED_W-1:0];
          default: begin
          end
        endcase
      end
      if (fin_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pix.valid) begin
            state <= S_BIN;
          end
        end
        S_BIN: begin
          if (hit) begin
            state <= S_RD;
          end else if (in_fend) begin
            state <= S_SCAN_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RD: state <= S_WR;
        S_WR: begin
          bin_vld[bin] <= 1'b1;
          state <= in_fend ? S_SCAN_RD : S_IDLE;
        end
        S_SCAN_RD:  state <= S_SCAN_MUL;
        S_SCAN_MUL: state <= S_SCAN_CMP;
        S_SCAN_CMP: begin
          if (idx == BIN_IDX_W'(BINS - 1)) begin
            state <= found_fin ? S_DIV_L : S_FIN;
          end else begin
            state <= S_SCAN_RD;
          end
        end
        S_DIV_L: begin
          if (div_last) begin
            state <= S_DIV_R;
          end
        end
        S_DIV_R: begin
          if (div_last) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_load) begin
            bin_vld <= '0;
            if (found) begin
              last_vld <= 1'b1;
              last_pos <= pos;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN_RD) || (state == S_SCAN_MUL) || (state == S_SCAN_CMP)) |-> !ram_we)
    else $error("bin RAM written during the bin scan");

  a_bins_cleared: assert property (@(posedge clk) disable iff (rst)
    ((state == S_IDLE) && ($past(state) == S_FIN)) |-> (bin_vld == '0))
    else $error("bin flags not cleared after a frame");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result loaded outside the finish step");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV_L) || (state == S_DIV_R)) |-> (div_d != '0))
    else $error("divider started with a zero divisor");

  a_div_only_found: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DIV_L) && ($past(state) == S_SCAN_CMP)) |-> found)
    else $error("divider started without a line");

endmodule
`default_nettype wire

// ===== hdl/lps_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
